[rtl/core/cmtl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmtl_pkg
// Shared types and constants for the cube map texel lookup core.
// ----------------------------------------------------------------------------
package cmtl_pkg;

	localparam int FACE_SIZE_DEF = 512;
	localparam int FACE_COUNT    = 6;
	localparam int COORD_W       = 9;
	localparam int DIR_W         = 16;
	localparam int MAG_W         = 17;
	localparam int NUM_W         = 25;
	localparam int TEXEL_W       = 24;
	localparam int FACE_W        = 3;
	localparam int COORD_SCALE   = 255;
	localparam int COORD_OFFSET  = 256;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [FACE_W-1:0] FACE_PZ = 3'd0;
	localparam logic [FACE_W-1:0] FACE_PX = 3'd1;
	localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NZ = 3'd3;
	localparam logic [FACE_W-1:0] FACE_NX = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NY = 3'd5;

	// classified item handed from front to back
	typedef struct packed {
		logic                       lookup;
		logic                       zero;
		logic [FACE_W-1:0]          face;
		logic [MAG_W-1:0]           major;
		logic signed [NUM_W-1:0]    num_u;
		logic signed [NUM_W-1:0]    num_v;
		logic [COORD_W-1:0]         column;
		logic [COORD_W-1:0]         row;
		logic [TEXEL_W-1:0]         texel;
	} item_t;

endpackage

[rtl/core/cmtl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmtl_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cmtl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/core/cmtl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmtl_front
// Accepts commands, picks the major axis and face, forms the numerators.
// ----------------------------------------------------------------------------
module cmtl_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              command,
	input  logic [cmtl_pkg::FACE_W-1:0]       face,
	input  logic [cmtl_pkg::COORD_W-1:0]      column,
	input  logic [cmtl_pkg::COORD_W-1:0]      row,
	input  logic [7:0]                        red_in,
	input  logic [7:0]                        green_in,
	input  logic [7:0]                        blue_in,
	input  logic signed [cmtl_pkg::DIR_W-1:0] dir_x,
	input  logic signed [cmtl_pkg::DIR_W-1:0] dir_y,
	input  logic signed [cmtl_pkg::DIR_W-1:0] dir_z,
	output logic                              q_valid,
	output cmtl_pkg::item_t                   q_item,
	input  logic                              q_pop
);
	import cmtl_pkg::*;

	localparam int QD = 2;

	item_t            slot_q [QD];
	logic [1:0]       cnt_q;
	logic             rd_q, wr_q;
	item_t            it;
	logic signed [MAG_W-1:0] x, y, z, ax, ay, az, nu, nv;
	logic             push;

	assign busy    = (cnt_q == 2'(QD));
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = slot_q[rd_q];

	always_comb begin
		x  = MAG_W'(dir_x);
		y  = MAG_W'(dir_y);
		z  = MAG_W'(dir_z);
		ax = x[MAG_W-1] ? -x : x;
		ay = y[MAG_W-1] ? -y : y;
		az = z[MAG_W-1] ? -z : z;
		it = '0;
		it.lookup = (command == CMD_LOOKUP);
		it.zero   = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
		it.column = column;
		it.row    = row;
		it.texel  = {red_in, green_in, blue_in};
		nv = y;
		if (az >= ax && az >= ay) begin
			it.major = az;
			if (!z[MAG_W-1]) begin
				it.face = FACE_PZ; nu = x;
			end else begin
				it.face = FACE_NZ; nu = -x;
			end
		end else if (ax >= ay) begin
			it.major = ax;
			if (!x[MAG_W-1]) begin
				it.face = FACE_PX; nu = -z;
			end else begin
				it.face = FACE_NX; nu = z;
			end
		end else begin
			it.major = ay;
			nu = x;
			if (!y[MAG_W-1]) begin
				it.face = FACE_PY; nv = -z;
			end else begin
				it.face = FACE_NY; nv = z;
			end
		end
		// times 255 as shift and subtract
		it.num_u = (NUM_W'(nu) <<< 8) - NUM_W'(nu);
		it.num_v = (NUM_W'(nv) <<< 8) - NUM_W'(nv);
		if (!it.lookup) begin
			it.face = face;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= it;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (q_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

[rtl/core/cmtl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmtl_back
// Runs the two floor divisions on one shared restoring divider, then the
// texel store access.
// ----------------------------------------------------------------------------
module cmtl_back #(
	parameter int FACE_SIZE = cmtl_pkg::FACE_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  cmtl_pkg::item_t              q_item,
	output logic                         q_pop,
	output logic                         done,
	output logic [7:0]                   red,
	output logic [7:0]                   green,
	output logic [7:0]                   blue,
	output logic [cmtl_pkg::FACE_W-1:0]  face_hit
);
	import cmtl_pkg::*;

	localparam int FB    = $clog2(FACE_SIZE);
	localparam int DEPTH = FACE_COUNT * FACE_SIZE * FACE_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int QW    = NUM_W - 1;
	localparam int SW    = $clog2(QW + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_OUT  = 3'd3;

	logic [2:0]       state_q;
	item_t            cur_q;
	logic             second_q;
	logic [SW-1:0]    step_q;
	logic [MAG_W-1:0] rem_q;
	logic [QW-1:0]    quo_q;
	logic [FB-1:0]    col_q, row_q;
	logic             fin;
	logic [MAG_W:0]   trial;
	logic [QW-1:0]    mag_n;
	logic             neg_n;
	logic signed [QW+1:0] qs;
	logic [FB-1:0]    coord;
	logic             wr_ok;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic [TEXEL_W-1:0] rd_data;

	always_comb begin
		logic signed [NUM_W-1:0] n;
		n     = second_q ? cur_q.num_v : cur_q.num_u;
		neg_n = n[NUM_W-1];
		mag_n = neg_n ? QW'(-n) : QW'(n);
	end

	// step 0 loads, steps 1 to QW shift, the step after that takes the result
	assign trial = {rem_q, quo_q[QW-1]} - {1'b0, cur_q.major};
	assign fin   = (step_q == SW'(QW + 1));

	// floor of the signed quotient, offset and saturated
	always_comb begin
		logic signed [QW+1:0] c;
		qs = {2'b00, quo_q};
		if (neg_n) begin
			qs = -qs - ((rem_q != '0) ? (QW+2)'(1) : '0);
		end
		c = qs + (QW+2)'(COORD_OFFSET);
		if (c < 0) begin
			coord = '0;
		end else if (c > (QW+2)'(FACE_SIZE - 1)) begin
			coord = FB'(FACE_SIZE - 1);
		end else begin
			coord = FB'(c);
		end
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign wr_ok = q_pop && !q_item.lookup && (q_item.face < FACE_W'(FACE_COUNT))
		&& ({3'b000, q_item.column} < (COORD_W+3)'(FACE_SIZE))
		&& ({3'b000, q_item.row} < (COORD_W+3)'(FACE_SIZE));
	assign wr_addr = AW'((q_item.face * FACE_SIZE + q_item.row) * FACE_SIZE
		+ q_item.column);
	assign rd_addr = AW'((cur_q.face * FACE_SIZE + row_q) * FACE_SIZE + col_q);

	cmtl_ram #(.WIDTH(TEXEL_W), .DEPTH(DEPTH)) u_store (
		.clk    (clk),
		.wr_en  (wr_ok),
		.wr_addr(wr_addr),
		.wr_data(q_item.texel),
		.rd_en  (state_q == ST_READ),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			second_q <= 1'b0;
			step_q   <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
			done     <= 1'b0;
			red      <= '0;
			green    <= '0;
			blue     <= '0;
			face_hit <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop && q_item.lookup) begin
						second_q <= 1'b0;
						step_q   <= '0;
						rem_q    <= '0;
						state_q  <= q_item.zero ? ST_OUT : ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						quo_q  <= mag_n;
						rem_q  <= '0;
						step_q <= SW'(1);
					end else if (!fin) begin
						if (!trial[MAG_W]) begin
							rem_q <= trial[MAG_W-1:0];
							quo_q <= {quo_q[QW-2:0], 1'b1};
						end else begin
							rem_q <= {rem_q[MAG_W-2:0], quo_q[QW-1]};
							quo_q <= {quo_q[QW-2:0], 1'b0};
						end
						step_q <= step_q + SW'(1);
					end else begin
						step_q <= '0;
						if (!second_q) begin
							col_q    <= coord;
							second_q <= 1'b1;
						end else begin
							row_q   <= coord;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					done     <= 1'b1;
					face_hit <= cur_q.zero ? '0 : cur_q.face;
					red      <= cur_q.zero ? '0 : rd_data[23:16];
					green    <= cur_q.zero ? '0 : rd_data[15:8];
					blue     <= cur_q.zero ? '0 : rd_data[7:0];
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/cube_map_texel_lookup_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_map_texel_lookup_core
// A lookup with a nonzero direction runs two 24-step divisions on one shared
// divider, then a store read and the output register. A write gives no done.
// A two-entry queue lets start run ahead of the divider. Reset clears
// control state only; texel contents are undefined until written. done is
// a one-cycle strobe that the receiver cannot stall.
// ----------------------------------------------------------------------------
module cube_map_texel_lookup_core #(
	parameter int FACE_SIZE = cmtl_pkg::FACE_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              command,
	input  logic [cmtl_pkg::FACE_W-1:0]       face,
	input  logic [cmtl_pkg::COORD_W-1:0]      column,
	input  logic [cmtl_pkg::COORD_W-1:0]      row,
	input  logic [7:0]                        red_in,
	input  logic [7:0]                        green_in,
	input  logic [7:0]                        blue_in,
	input  logic signed [cmtl_pkg::DIR_W-1:0] dir_x,
	input  logic signed [cmtl_pkg::DIR_W-1:0] dir_y,
	input  logic signed [cmtl_pkg::DIR_W-1:0] dir_z,
	output logic                              done,
	output logic [7:0]                        red,
	output logic [7:0]                        green,
	output logic [7:0]                        blue,
	output logic [cmtl_pkg::FACE_W-1:0]       face_hit
);
	import cmtl_pkg::*;

	logic  q_valid, q_pop;
	item_t q_item;

	cmtl_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .face(face), .column(column), .row(row),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	cmtl_back #(.FACE_SIZE(FACE_SIZE)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop), .done(done), .red(red), .green(green), .blue(blue),
		.face_hit(face_hit)
	);

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for two cycles");
	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (face_hit < FACE_W'(FACE_COUNT))) else $error("face out of range");

endmodule

[tb/tb_cube_map_texel_lookup_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cube_map_texel_lookup_core
// Self-checking bench for the cube map texel lookup core. Texel writes and
// direction lookups are driven, some with random gaps. A local predictor keeps a
// shadow of every texel written and works out the colour and face of each
// lookup. Each done strobe is checked in order against the queue of pending
// colours. Lookups only read texels that were written first.
// ----------------------------------------------------------------------------
module tb_cube_map_texel_lookup_core;
	import cmtl_pkg::*;

	typedef struct {
		logic [7:0]        r;
		logic [7:0]        g;
		logic [7:0]        b;
		logic [FACE_W-1:0] f;
	} colour_hit_t;

	localparam int FSIZE       = FACE_SIZE_DEF;
	localparam int SETTLE_CYC  = 80;
	localparam int CYCLE_LIMIT = 2000000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic                    command = CMD_WRITE;
	logic [FACE_W-1:0]       face = '0;
	logic [COORD_W-1:0]      column = '0;
	logic [COORD_W-1:0]      row = '0;
	logic [7:0]              red_in = '0;
	logic [7:0]              green_in = '0;
	logic [7:0]              blue_in = '0;
	logic signed [DIR_W-1:0] dir_x = '0;
	logic signed [DIR_W-1:0] dir_y = '0;
	logic signed [DIR_W-1:0] dir_z = '0;
	logic                    done;
	logic [7:0]              red;
	logic [7:0]              green;
	logic [7:0]              blue;
	logic [FACE_W-1:0]       face_hit;

	logic [TEXEL_W-1:0] texel_shadow [int];
	colour_hit_t        pending_colours [$];
	int                 mismatches = 0;
	int                 cycles = 0;
	int                 n_writes = 0;
	int                 n_lookups = 0;
	int                 n_checked = 0;
	bit                 gaps_on = 1'b1;

	cube_map_texel_lookup_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .face(face), .column(column), .row(row),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.done(done), .red(red), .green(green), .blue(blue), .face_hit(face_hit)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	// floor(n * 255 / m) + 256 with flooring towards minus infinity, clamped to the face
	function automatic int face_coord(input int n, input int m);
		int p;
		int q;
		p = n * COORD_SCALE;
		q = p / m;
		if ((p % m) != 0 && p < 0)
			q = q - 1;
		q = q + COORD_OFFSET;
		if (q < 0)
			q = 0;
		if (q > FSIZE - 1)
			q = FSIZE - 1;
		return q;
	endfunction

	// major axis selection; ties go to z, then x
	function automatic void map_direction(input int x, input int y, input int z,
			output logic [FACE_W-1:0] f, output int addr, output bit is_zero);
		int ax, ay, az, m, u, v;
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		az = z < 0 ? -z : z;
		is_zero = (x == 0 && y == 0 && z == 0);
		if (az >= ax && az >= ay) begin
			m = az;
			if (z >= 0) begin f = FACE_PZ; u = x; v = y; end
			else begin f = FACE_NZ; u = -x; v = y; end
		end else if (ax >= ay) begin
			m = ax;
			if (x >= 0) begin f = FACE_PX; u = -z; v = y; end
			else begin f = FACE_NX; u = z; v = y; end
		end else begin
			m = ay;
			if (y >= 0) begin f = FACE_PY; u = x; v = -z; end
			else begin f = FACE_NY; u = x; v = z; end
		end
		if (is_zero)
			addr = 0;
		else
			addr = (int'(f) * FSIZE + face_coord(v, m)) * FSIZE + face_coord(u, m);
	endfunction

	// one transfer; the expectation is formed at the accepting edge
	task automatic send_item(input logic cmd, input logic [FACE_W-1:0] f,
			input int col, input int rw, input logic [TEXEL_W-1:0] rgb,
			input int x, input int y, input int z);
		int gap;
		logic [FACE_W-1:0] fh;
		int addr;
		bit is_zero;
		colour_hit_t hit;
		gap = gaps_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		command  <= cmd;
		face     <= f;
		column   <= COORD_W'(col);
		row      <= COORD_W'(rw);
		red_in   <= rgb[23:16];
		green_in <= rgb[15:8];
		blue_in  <= rgb[7:0];
		dir_x    <= DIR_W'(x);
		dir_y    <= DIR_W'(y);
		dir_z    <= DIR_W'(z);
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (cmd == CMD_WRITE) begin
			n_writes++;
			if (f < FACE_COUNT)
				texel_shadow[(int'(f) * FSIZE + rw) * FSIZE + col] = rgb;
		end else begin
			n_lookups++;
			map_direction(x, y, z, fh, addr, is_zero);
			if (is_zero) begin
				hit = '{8'd0, 8'd0, 8'd0, FACE_PZ};
			end else begin
				hit.r = texel_shadow[addr][23:16];
				hit.g = texel_shadow[addr][15:8];
				hit.b = texel_shadow[addr][7:0];
				hit.f = fh;
			end
			pending_colours.push_back(hit);
		end
	endtask

	task automatic do_write(input logic [FACE_W-1:0] f, input int col, input int rw,
			input logic [TEXEL_W-1:0] rgb);
		send_item(CMD_WRITE, f, col, rw, rgb, $urandom, $urandom, $urandom);
	endtask

	// the texel a lookup reads is always written first
	task automatic do_lookup(input int x, input int y, input int z);
		logic [FACE_W-1:0] f;
		int addr;
		bit is_zero;
		// components as the 16-bit ports carry them
		x = int'($signed(DIR_W'(x)));
		y = int'($signed(DIR_W'(y)));
		z = int'($signed(DIR_W'(z)));
		map_direction(x, y, z, f, addr, is_zero);
		if (!is_zero && !texel_shadow.exists(addr))
			do_write(f, addr % FSIZE, (addr / FSIZE) % FSIZE, TEXEL_W'($urandom));
		send_item(CMD_LOOKUP, FACE_W'($urandom), $urandom, $urandom,
			TEXEL_W'($urandom), x, y, z);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_colours.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic test_directed();
		gaps_on = 1'b0;
		do_write(FACE_PZ, 0, 0, 24'h000000);
		do_write(FACE_NY, 511, 511, 24'hFFFFFF);
		do_write(3'd6, 100, 100, 24'h123456);
		do_write(3'd7, 511, 0, 24'hABCDEF);
		do_lookup(0, 0, 0);
		do_lookup(100, 100, 100);
		do_lookup(100, 100, -50);
		do_lookup(-32768, -32768, -32768);
		do_lookup(32767, 0, 0);
		do_lookup(-32768, 32767, 0);
		do_lookup(0, -32768, 0);
		do_lookup(0, 32767, -32768);
		do_lookup(0, 0, 1);
		do_lookup(1, -1, 1);
		do_lookup(-3, 7, 2);
	endtask

	task automatic rand_direction(output int x, output int y, output int z);
		int mode;
		int lim;
		mode = $urandom_range(0, 9);
		lim = (mode < 4) ? 32767 : (mode < 7 ? 255 : 4);
		x = $urandom_range(0, 2 * lim + 1) - lim - 1;
		y = $urandom_range(0, 2 * lim + 1) - lim - 1;
		z = $urandom_range(0, 2 * lim + 1) - lim - 1;
		if (mode == 8) begin
			// force a tie between two axes
			case ($urandom_range(0, 2))
				0: y = ($urandom_range(0, 1) ? x : -x);
				1: z = ($urandom_range(0, 1) ? x : -x);
				default: z = ($urandom_range(0, 1) ? y : -y);
			endcase
		end
		if (mode == 9 && $urandom_range(0, 3) == 0) begin
			x = 0; y = 0; z = 0;
		end
	endtask

	task automatic test_random(input int count);
		int x, y, z;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0)
				gaps_on = $urandom_range(0, 2) != 0;
			if ($urandom_range(0, 4) == 0) begin
				do_write(FACE_W'($urandom_range(0, 7)), $urandom_range(0, 511),
					$urandom_range(0, 511), TEXEL_W'($urandom));
			end else begin
				rand_direction(x, y, z);
				do_lookup(x, y, z);
			end
		end
	endtask

	task automatic test_overwrite();
		// rewrite a texel already read, then read it again
		gaps_on = 1'b1;
		do_lookup(500, -20, 30);
		do_lookup(500, -20, 30);
		do_write(FACE_PX, 240, 245, 24'h5A5AA5);
		do_lookup(500, -20, 30);
	endtask

	always @(posedge clk) begin
		colour_hit_t want;
		if (arst_n && done) begin
			if (pending_colours.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result rgb=%h%h%h face=%0d", red, green, blue,
						face_hit);
			end else begin
				want = pending_colours.pop_front();
				n_checked++;
				if (red !== want.r || green !== want.g || blue !== want.b ||
						face_hit !== want.f) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected rgb=%h%h%h face=%0d, got rgb=%h%h%h face=%0d",
							want.r, want.g, want.b, want.f, red, green, blue, face_hit);
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_overwrite();
		test_random(180);
		wait_drained();
		test_random(180);
		wait_drained();
		if (pending_colours.size() != 0)
			mismatches++;
		$display("covered %0d texel writes and %0d lookups, %0d results checked",
			n_writes, n_lookups, n_checked);
		$display("all six faces, axis ties, extreme and zero directions, bad faces");
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
